/* rtl/radix_digit_converter_macros.svh */
// ----------------------------------------------------------------------------
// Radix digit converter assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define RDC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// Radix digit converter package
// Widths, digit store geometry, reciprocal table, shared types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdc_pkg;

   localparam int VALUE_BITS = 31;
   localparam int MAX_DIGITS = 31;
   localparam int RADIX_BITS = 6;
   localparam int DIGIT_BITS = 6;
   localparam int CHAR_BITS  = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd2;

   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN  = 6'd10;
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 7'd48;  // '0'
   localparam logic [CHAR_BITS-1:0]  CHAR_ALPHA = 7'd55;  // 'A' minus ten

   localparam int COUNT_BITS      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_BITS        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int BANK_DEPTH      = 2 ** IDX_BITS;
   localparam int SLOT_BITS       = 1;
   localparam int JOB_SLOTS       = 2 ** SLOT_BITS;
   localparam int LEVEL_BITS      = $clog2(JOB_SLOTS + 1);
   localparam int STORE_DEPTH     = JOB_SLOTS * BANK_DEPTH;
   localparam int STORE_ADDR_BITS = SLOT_BITS + IDX_BITS;

   // Remainder before correction stays below twice the radix.
   localparam int REM_BITS   = RADIX_BITS + 1;
   // Scaled reciprocal keeps the quotient estimate within one of exact.
   localparam int RECIP_BITS = VALUE_BITS + 1;
   localparam logic [RECIP_BITS:0] RECIP_NUM = {1'b1, {RECIP_BITS{1'b0}}};

   localparam logic [RECIP_BITS-1:0] RECIP_TABLE [RADIX_MIN:RADIX_MAX] = '{
      RECIP_BITS'(RECIP_NUM / 2),  RECIP_BITS'(RECIP_NUM / 3),  RECIP_BITS'(RECIP_NUM / 4),
      RECIP_BITS'(RECIP_NUM / 5),  RECIP_BITS'(RECIP_NUM / 6),  RECIP_BITS'(RECIP_NUM / 7),
      RECIP_BITS'(RECIP_NUM / 8),  RECIP_BITS'(RECIP_NUM / 9),  RECIP_BITS'(RECIP_NUM / 10),
      RECIP_BITS'(RECIP_NUM / 11), RECIP_BITS'(RECIP_NUM / 12), RECIP_BITS'(RECIP_NUM / 13),
      RECIP_BITS'(RECIP_NUM / 14), RECIP_BITS'(RECIP_NUM / 15), RECIP_BITS'(RECIP_NUM / 16),
      RECIP_BITS'(RECIP_NUM / 17), RECIP_BITS'(RECIP_NUM / 18), RECIP_BITS'(RECIP_NUM / 19),
      RECIP_BITS'(RECIP_NUM / 20), RECIP_BITS'(RECIP_NUM / 21), RECIP_BITS'(RECIP_NUM / 22),
      RECIP_BITS'(RECIP_NUM / 23), RECIP_BITS'(RECIP_NUM / 24), RECIP_BITS'(RECIP_NUM / 25),
      RECIP_BITS'(RECIP_NUM / 26), RECIP_BITS'(RECIP_NUM / 27), RECIP_BITS'(RECIP_NUM / 28),
      RECIP_BITS'(RECIP_NUM / 29), RECIP_BITS'(RECIP_NUM / 30), RECIP_BITS'(RECIP_NUM / 31),
      RECIP_BITS'(RECIP_NUM / 32), RECIP_BITS'(RECIP_NUM / 33), RECIP_BITS'(RECIP_NUM / 34),
      RECIP_BITS'(RECIP_NUM / 35), RECIP_BITS'(RECIP_NUM / 36)
   };

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MUL,
      FR_FIX
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_SHOW
   } back_state_type;

   typedef struct packed {
      logic                  push;
      logic [COUNT_BITS-1:0] count;
   } job_push_type;

   typedef struct packed {
      logic                  full;
      logic                  empty;
      logic [COUNT_BITS-1:0] head_count;
      logic [SLOT_BITS-1:0]  head_slot;
      logic [SLOT_BITS-1:0]  tail_slot;
   } job_status_type;

   function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] eff;
      eff = r;
      if (r < RADIX_MIN) begin
         eff = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         eff = RADIX_MAX;
      end
      return eff;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] d_ext;
      d_ext = CHAR_BITS'(d);
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + d_ext;
      end
      return CHAR_ALPHA + d_ext;
   endfunction

endpackage

/* rtl/rdc_channels.sv */
// ----------------------------------------------------------------------------
// Radix digit converter channels
// Valid/ready interfaces for the request, response and register write ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rdc_req_if;
   logic                            valid;
   logic                            ready;
   logic [rdc_pkg::VALUE_BITS-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rdc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rdc_pkg::CHAR_BITS-1:0]   digit_char;
   logic                            last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

interface rdc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rdc_pkg::RADIX_BITS-1:0]  radix;

   modport source (output valid, output radix, input ready);
   modport sink   (input valid, input radix, output ready);
endinterface

/* rtl/rdc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rdc_front.sv */
// ----------------------------------------------------------------------------
// Radix digit converter front end
// Accepts a value and peels off digits, least significant first, by
// reciprocal multiply and one-step remainder correction into a free bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radix_digit_converter_macros.svh"

module rdc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rdc_pkg::RADIX_BITS-1:0]        radix,
   rdc_req_if.sink                               req_chan,
   input  rdc_pkg::job_status_type               job_status,
   output rdc_pkg::job_push_type                 job_push,
   output logic                                  store_wr_en,
   output logic [rdc_pkg::STORE_ADDR_BITS-1:0]   store_wr_addr,
   output logic [rdc_pkg::DIGIT_BITS-1:0]        store_wr_data
);

   localparam int PROD_BITS = rdc_pkg::VALUE_BITS + rdc_pkg::RECIP_BITS;
   localparam int RPROD_BITS = rdc_pkg::REM_BITS + rdc_pkg::RADIX_BITS;

   rdc_pkg::front_state_type state_ff, state_in;

   logic [rdc_pkg::VALUE_BITS-1:0] quo_ff, quo_in;
   logic [rdc_pkg::VALUE_BITS-1:0] qest_ff, qest_in;
   logic [rdc_pkg::COUNT_BITS-1:0] count_ff, count_in;

   logic                           accept;
   logic [rdc_pkg::RADIX_BITS-1:0] eff_radix;
   logic [rdc_pkg::RECIP_BITS-1:0] recip;
   logic [PROD_BITS-1:0]           mul_full;
   logic [RPROD_BITS-1:0]          rem_prod;
   logic [rdc_pkg::REM_BITS-1:0]   rem_raw;
   logic [rdc_pkg::REM_BITS-1:0]   rem_fix;
   logic                           rem_big;
   logic [rdc_pkg::VALUE_BITS-1:0] quo_next;
   logic                           has_room;
   logic [rdc_pkg::COUNT_BITS-1:0] count_step;

   assign eff_radix = rdc_pkg::clamp_radix(radix);
   assign recip     = rdc_pkg::RECIP_TABLE[eff_radix];

   // Quotient estimate: floor(x * recip / 2^RECIP_BITS) is exact or one short.
   assign mul_full = PROD_BITS'(quo_ff) * PROD_BITS'(recip);
   assign qest_in  = mul_full[PROD_BITS-1:rdc_pkg::RECIP_BITS];

   // Remainder fits in the low bits, so subtract there only.
   assign rem_prod = RPROD_BITS'(qest_ff[rdc_pkg::REM_BITS-1:0]) * RPROD_BITS'(eff_radix);
   assign rem_raw  = quo_ff[rdc_pkg::REM_BITS-1:0] - rem_prod[rdc_pkg::REM_BITS-1:0];
   assign rem_big  = rem_raw >= rdc_pkg::REM_BITS'(eff_radix);
   assign rem_fix  = rem_big ? (rem_raw - rdc_pkg::REM_BITS'(eff_radix)) : rem_raw;
   assign quo_next = qest_ff + rdc_pkg::VALUE_BITS'(rem_big);

   assign has_room   = count_ff < rdc_pkg::COUNT_BITS'(rdc_pkg::MAX_DIGITS);
   assign count_step = has_room ? (count_ff + rdc_pkg::COUNT_BITS'(1)) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdc_pkg::FR_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      qest_ff <= qest_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rdc_pkg::FR_IDLE: begin
            if (accept) begin
               state_in = rdc_pkg::FR_MUL;
            end
         end
         rdc_pkg::FR_MUL: begin
            state_in = rdc_pkg::FR_FIX;
         end
         rdc_pkg::FR_FIX: begin
            if (quo_next == '0) begin
               state_in = rdc_pkg::FR_IDLE;
            end else begin
               state_in = rdc_pkg::FR_MUL;
            end
         end
         default: begin
            state_in = rdc_pkg::FR_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      accept         = 1'b0;
      quo_in         = quo_ff;
      count_in       = count_ff;
      store_wr_en    = 1'b0;
      job_push.push  = 1'b0;
      job_push.count = count_step;
      case (state_ff)
         rdc_pkg::FR_IDLE: begin
            // A free bank exists only while the job queue has a slot.
            req_chan.ready = !job_status.full;
            accept         = req_chan.valid && !job_status.full;
            if (accept) begin
               quo_in   = req_chan.value;
               count_in = '0;
            end
         end
         rdc_pkg::FR_MUL: begin
         end
         rdc_pkg::FR_FIX: begin
            // Drop digits beyond MAX_DIGITS per value.
            store_wr_en   = has_room;
            quo_in        = quo_next;
            count_in      = count_step;
            job_push.push = quo_next == '0;
         end
         default: begin
         end
      endcase
   end

   assign store_wr_addr = {job_status.tail_slot, count_ff[rdc_pkg::IDX_BITS-1:0]};
   assign store_wr_data = rem_fix[rdc_pkg::DIGIT_BITS-1:0];

   `RDC_ASSERT_IMPLY(a_rem_in_range, state_ff == rdc_pkg::FR_FIX,
      rem_fix < rdc_pkg::REM_BITS'(eff_radix), "corrected remainder not below radix")
   `RDC_ASSERT_IMPLY(a_accept_has_slot, accept, !job_status.full,
      "value taken with no free digit bank")

endmodule

/* rtl/rdc_job_fifo.sv */
// ----------------------------------------------------------------------------
// Radix digit converter job queue
// Two-slot queue of finished digit counts; the slot index names the bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radix_digit_converter_macros.svh"

module rdc_job_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  rdc_pkg::job_push_type   job_push,
   input  logic                    pop,
   output rdc_pkg::job_status_type job_status
);

   logic [rdc_pkg::COUNT_BITS-1:0] count_mem_ff [rdc_pkg::JOB_SLOTS];
   logic [rdc_pkg::SLOT_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rdc_pkg::SLOT_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rdc_pkg::LEVEL_BITS-1:0] level_ff, level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_push.push) begin
         count_mem_ff[wr_ptr_ff] <= job_push.count;
      end
   end

   always_comb begin
      wr_ptr_in = job_push.push ? (wr_ptr_ff + rdc_pkg::SLOT_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + rdc_pkg::SLOT_BITS'(1)) : rd_ptr_ff;
      case ({job_push.push, pop})
         2'b10:   level_in = level_ff + rdc_pkg::LEVEL_BITS'(1);
         2'b01:   level_in = level_ff - rdc_pkg::LEVEL_BITS'(1);
         default: level_in = level_ff;
      endcase
   end

   assign job_status.full       = level_ff == rdc_pkg::LEVEL_BITS'(rdc_pkg::JOB_SLOTS);
   assign job_status.empty      = level_ff == '0;
   assign job_status.head_count = count_mem_ff[rd_ptr_ff];
   assign job_status.head_slot  = rd_ptr_ff;
   assign job_status.tail_slot  = wr_ptr_ff;

   `RDC_ASSERT_IMPLY(a_push_not_full, job_push.push, !job_status.full,
      "job pushed into a full queue")
   `RDC_ASSERT_IMPLY(a_pop_not_empty, pop, !job_status.empty,
      "job popped from an empty queue")

endmodule

/* rtl/rdc_back.sv */
// ----------------------------------------------------------------------------
// Radix digit converter back end
// Reads the head job's bank most significant digit first and sends one
// ASCII character per beat, flagging the last one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radix_digit_converter_macros.svh"

module rdc_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rdc_pkg::job_status_type               job_status,
   output logic                                  pop,
   output logic [rdc_pkg::STORE_ADDR_BITS-1:0]   store_rd_addr,
   input  logic [rdc_pkg::DIGIT_BITS-1:0]        store_rd_data,
   rdc_rsp_if.source                             rsp_chan
);

   rdc_pkg::back_state_type state_ff, state_in;

   logic [rdc_pkg::IDX_BITS-1:0]   idx_ff, idx_in;
   logic [rdc_pkg::COUNT_BITS-1:0] head_less;
   logic                           at_last;
   logic                           beat;

   assign head_less = job_status.head_count - rdc_pkg::COUNT_BITS'(1);
   assign at_last   = idx_ff == '0;
   assign beat      = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdc_pkg::BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rdc_pkg::BK_IDLE: begin
            if (!job_status.empty) begin
               state_in = rdc_pkg::BK_READ;
            end
         end
         rdc_pkg::BK_READ: begin
            state_in = rdc_pkg::BK_SHOW;
         end
         rdc_pkg::BK_SHOW: begin
            if (rsp_chan.ready) begin
               state_in = at_last ? rdc_pkg::BK_IDLE : rdc_pkg::BK_READ;
            end
         end
         default: begin
            state_in = rdc_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_chan.valid = 1'b0;
      pop            = 1'b0;
      idx_in         = idx_ff;
      case (state_ff)
         rdc_pkg::BK_IDLE: begin
            if (!job_status.empty) begin
               idx_in = head_less[rdc_pkg::IDX_BITS-1:0];
            end
         end
         rdc_pkg::BK_READ: begin
         end
         rdc_pkg::BK_SHOW: begin
            rsp_chan.valid = 1'b1;
            // Hold the bank until its last beat so the front cannot reuse it.
            if (rsp_chan.ready) begin
               pop = at_last;
               if (!at_last) begin
                  idx_in = idx_ff - rdc_pkg::IDX_BITS'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign store_rd_addr       = {job_status.head_slot, idx_ff};
   assign rsp_chan.digit_char = rdc_pkg::digit_to_ascii(store_rd_data);
   assign rsp_chan.last_digit = at_last;

   `RDC_ASSERT_IMPLY(a_valid_has_job, rsp_chan.valid, !job_status.empty,
      "character shown with no job at the queue head")
   `RDC_ASSERT_NEXT(a_last_returns_idle, beat && rsp_chan.last_digit,
      state_ff == rdc_pkg::BK_IDLE, "back end busy after the last beat")

endmodule

/* rtl/radix_digit_converter.sv */
// ----------------------------------------------------------------------------
// Radix digit converter
// Output starts once the front has pushed every digit of a value.
// The front works each digit in a multiply and a correction state on its
// one reciprocal multiplier; the back reads each character from the digit
// store read port, then shows it. The two overlap on separate banks.
// Reset: synchronous; radix returns to 2, queue and both sequencers go idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter (
   input  logic        clock,
   input  logic        reset,
   rdc_req_if.sink     req_chan,
   rdc_rsp_if.source   rsp_chan,
   rdc_csr_if.sink     csr_chan
);

   logic [rdc_pkg::RADIX_BITS-1:0]      radix_ff, radix_in;
   rdc_pkg::job_push_type               job_push;
   rdc_pkg::job_status_type             job_status;
   logic                                pop;
   logic                                store_wr_en;
   logic [rdc_pkg::STORE_ADDR_BITS-1:0] store_wr_addr;
   logic [rdc_pkg::DIGIT_BITS-1:0]      store_wr_data;
   logic [rdc_pkg::STORE_ADDR_BITS-1:0] store_rd_addr;
   logic [rdc_pkg::DIGIT_BITS-1:0]      store_rd_data;

   assign csr_chan.ready = 1'b1;
   assign radix_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.radix : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rdc_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   rdc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .radix         (radix_ff),
      .req_chan      (req_chan),
      .job_status    (job_status),
      .job_push      (job_push),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data)
   );

   rdc_ram #(
      .WIDTH (rdc_pkg::DIGIT_BITS),
      .DEPTH (rdc_pkg::STORE_DEPTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   rdc_job_fifo u_job_fifo (
      .clock      (clock),
      .reset      (reset),
      .job_push   (job_push),
      .pop        (pop),
      .job_status (job_status)
   );

   rdc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_status    (job_status),
      .pop           (pop),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .rsp_chan      (rsp_chan)
   );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Radix digit converter testbench
// Drives values through the request channel under several radix settings.
// Every character beat on the response channel is checked against digit
// strings from the vector table or the predictor. Both sides idle at random,
// and at one point the response side holds off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned PHASE_COUNT  = 8;
   localparam int unsigned PHASE_ITEMS  = 40;
   localparam int unsigned DRAIN_CYCLES = 80;
   localparam int unsigned REPORT_MAX   = 10;
   localparam longint unsigned VALUE_MAX = 64'd2147483647;
   localparam logic [rdc_pkg::CHAR_BITS-1:0] ASCII_UPPER_A = 7'd65;

   typedef struct packed {
      logic [rdc_pkg::CHAR_BITS-1:0] digit_char;
      logic                          last_digit;
   } char_beat_type;

   typedef struct {
      logic [rdc_pkg::RADIX_BITS-1:0] radix;
      logic [rdc_pkg::VALUE_BITS-1:0] value;
      string                          digits;
   } vector_row_type;

   // An empty digit string leaves the row to the predictor.
   localparam int unsigned VECTOR_COUNT = 25;
   vector_row_type directed_vectors [VECTOR_COUNT] = '{
      '{6'd2,  31'd0,          "0"},
      '{6'd2,  31'd1,          "1"},
      '{6'd2,  31'd5,          "101"},
      '{6'd2,  31'h7FFFFFFF,   ""},
      '{6'd2,  31'h40000000,   ""},
      '{6'd10, 31'd0,          "0"},
      '{6'd10, 31'd9,          "9"},
      '{6'd10, 31'd2147483647, "2147483647"},
      '{6'd10, 31'd1000000,    "1000000"},
      '{6'd16, 31'd255,        "FF"},
      '{6'd16, 31'h7FFFFFFF,   "7FFFFFFF"},
      '{6'd16, 31'h55555555,   "55555555"},
      '{6'd16, 31'h2AAAAAAA,   "2AAAAAAA"},
      '{6'd36, 31'd35,         "Z"},
      '{6'd36, 31'd36,         "10"},
      '{6'd36, 31'h7FFFFFFF,   ""},
      '{6'd36, 31'd0,          "0"},
      '{6'd0,  31'd6,          "110"},
      '{6'd1,  31'd7,          "111"},
      '{6'd37, 31'd71,         "1Z"},
      '{6'd63, 31'd1295,       "ZZ"},
      '{6'd8,  31'h7FFFFFFF,   ""},
      '{6'd7,  31'd48,         "66"},
      '{6'd3,  31'h7FFFFFFF,   ""},
      '{6'd35, 31'd34,         "Y"}
   };

   logic clock;
   logic reset;

   rdc_req_if req_if ();
   rdc_rsp_if rsp_if ();
   rdc_csr_if csr_if ();

   radix_digit_converter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   char_beat_type                  pending_chars [$];
   logic [rdc_pkg::RADIX_BITS-1:0] active_radix = rdc_pkg::RADIX_RESET;
   string                          typed_digits = "";
   int unsigned                    failures = 0;
   int unsigned                    cycle_count = 0;
   int unsigned                    rsp_wait = 0;
   bit                             rsp_took = 0;
   bit                             idle_on = 1;
   bit                             hold_go = 0;
   bit                             hold_active = 0;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.value  = '0;
      rsp_if.ready  = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.radix  = '0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[radix_digit_converter] ERROR");
         $finish;
      end
   end

   // Expected characters, most significant digit first, for one value.
   function automatic void predict_digits(input logic [rdc_pkg::VALUE_BITS-1:0] value,
                                          input logic [rdc_pkg::RADIX_BITS-1:0] radix);
      logic [rdc_pkg::DIGIT_BITS-1:0] digits [rdc_pkg::MAX_DIGITS];
      int unsigned                    base;
      int unsigned                    quot;
      int unsigned                    count;
      char_beat_type                  beat;
      base  = (radix < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN :
              (radix > rdc_pkg::RADIX_MAX) ? rdc_pkg::RADIX_MAX : radix;
      quot  = value;
      count = 0;
      // Zero still yields one digit.
      do begin
         if (count < rdc_pkg::MAX_DIGITS) begin
            digits[count] = rdc_pkg::DIGIT_BITS'(quot % base);
            count++;
         end
         quot = quot / base;
      end while (quot != 0);
      for (int k = count - 1; k >= 0; k--) begin
         if (digits[k] < 10)
            beat.digit_char = rdc_pkg::CHAR_ZERO + rdc_pkg::CHAR_BITS'(digits[k]);
         else
            beat.digit_char = ASCII_UPPER_A + rdc_pkg::CHAR_BITS'(digits[k] - 10);
         beat.last_digit = (k == 0);
         pending_chars.push_back(beat);
      end
   endfunction

   function automatic logic [rdc_pkg::VALUE_BITS-1:0] draw_value(
         input logic [rdc_pkg::RADIX_BITS-1:0] radix);
      longint unsigned power;
      int unsigned     base;
      int unsigned     steps;
      int unsigned     pick;
      base = (radix < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN :
             (radix > rdc_pkg::RADIX_MAX) ? rdc_pkg::RADIX_MAX : radix;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         return rdc_pkg::VALUE_BITS'($urandom());
      if (pick < 6)
         return rdc_pkg::VALUE_BITS'($urandom_range(0, 1000));
      if (pick < 8) begin
         // Land on a power of the base, or one either side of it.
         power = 1;
         steps = $urandom_range(1, rdc_pkg::MAX_DIGITS);
         for (int k = 0; k < steps; k++) begin
            if (power * base <= VALUE_MAX)
               power = power * base;
         end
         return rdc_pkg::VALUE_BITS'(power + $urandom_range(0, 2) - 1);
      end
      if (pick == 8)
         return rdc_pkg::VALUE_BITS'(VALUE_MAX);
      return rdc_pkg::VALUE_BITS'($urandom_range(0, 1));
   endfunction

   // Watch all three channels at the rising edge.
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            active_radix = csr_if.radix;
         if (req_if.valid && req_if.ready) begin
            if (typed_digits.len() != 0) begin
               for (int i = 0; i < typed_digits.len(); i++) begin
                  want.digit_char = rdc_pkg::CHAR_BITS'(typed_digits[i]);
                  want.last_digit = (i == typed_digits.len() - 1);
                  pending_chars.push_back(want);
               end
            end else begin
               predict_digits(req_if.value, active_radix);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_took = 1;
            if (pending_chars.size() == 0) begin
               failures++;
               if (failures <= REPORT_MAX)
                  $display("unexpected beat: char %0d last %0b",
                           rsp_if.digit_char, rsp_if.last_digit);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_if.digit_char !== want.digit_char
                   || rsp_if.last_digit !== want.last_digit) begin
                  failures++;
                  if (failures <= REPORT_MAX)
                     $display("char mismatch: expected %0d last %0b, got %0d last %0b",
                              want.digit_char, want.last_digit,
                              rsp_if.digit_char, rsp_if.last_digit);
               end
            end
         end
      end
   end

   // Response side: draw a wait per beat, or hold off while the stall runs.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            rsp_took = 0;
            rsp_wait = idle_on ? $urandom_range(0, 19) : 0;
         end
         if (hold_active) begin
            rsp_if.ready <= 1'b0;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      wait (hold_go);
      hold_active = 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 0;
   end

   task automatic send_value(input logic [rdc_pkg::VALUE_BITS-1:0] value,
                             input string digits);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.value <= value;
      typed_digits = digits;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop the request and wait until every expected character is out.
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_radix(input logic [rdc_pkg::RADIX_BITS-1:0] radix);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.radix <= radix;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      logic [rdc_pkg::RADIX_BITS-1:0] phase_radix;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < VECTOR_COUNT; i++) begin
         if (directed_vectors[i].radix != active_radix) begin
            settle();
            write_radix(directed_vectors[i].radix);
         end
         send_value(directed_vectors[i].value, directed_vectors[i].digits);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0)
            phase_radix = rdc_pkg::RADIX_MIN;
         else if (phase == 1)
            phase_radix = rdc_pkg::RADIX_MAX;
         else
            phase_radix = rdc_pkg::RADIX_BITS'($urandom_range(0, 63));
         settle();
         write_radix(phase_radix);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Redraw idling every ten items so some stretches run flat out.
            if (n % 10 == 0)
               idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 2 && n == 5)
               hold_go = 1;
            send_value(draw_value(phase_radix), "");
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_chars.size() == 0)
         $display("[radix_digit_converter] OK");
      else
         $display("[radix_digit_converter] ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/rdc_pkg.sv
rtl/rdc_channels.sv
rtl/rdc_ram.sv
rtl/rdc_front.sv
rtl/rdc_job_fifo.sv
rtl/rdc_back.sv
rtl/radix_digit_converter.sv
tb/tb_top.sv
